// ===== hw/rtl/box_shell_point_sampler_macros.svh =====
`ifndef BOX_SHELL_POINT_SAMPLER_MACROS_SVH
`define BOX_SHELL_POINT_SAMPLER_MACROS_SVH

// same-cycle check, switched off while reset is low
`define BSPS_ASSERT_NOW(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle check, switched off while reset is low
`define BSPS_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== hw/rtl/bsps_pkg.sv =====
`timescale 1ns / 1ps

package bsps_pkg;

    localparam int RAND_BITS      = 16;
    localparam int ORIGIN_BITS    = 19;
    localparam int POS_BITS       = 20;
    localparam int MODE_BITS      = 3;
    localparam int CFG_INDEX_BITS = 3;

    // register reset values, 1/16 mm
    localparam int INNER_RESET = 1024;
    localparam int WALL_RESET  = 16;

    localparam logic signed [POS_BITS-1:0] POS_MAX = 20'sh7FFFF;
    localparam logic signed [POS_BITS-1:0] POS_MIN = 20'sh80000;

    // region codes
    localparam logic [MODE_BITS-1:0] MODE_CENTRE    = 3'd0;
    localparam logic [MODE_BITS-1:0] MODE_Z_ENDCAP  = 3'd1;
    localparam logic [MODE_BITS-1:0] MODE_SHELL     = 3'd2;
    localparam logic [MODE_BITS-1:0] MODE_INSIDE    = 3'd3;
    localparam logic [MODE_BITS-1:0] MODE_Z_FACE    = 3'd4;
    localparam logic [MODE_BITS-1:0] MODE_ALL_FACES = 3'd5;

    // register indexes
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INNER_X        = 3'd0;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INNER_Y        = 3'd1;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_INNER_Z        = 3'd2;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_WALL_THICKNESS = 3'd3;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_X       = 3'd4;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Y       = 3'd5;
    localparam logic [CFG_INDEX_BITS-1:0] CFG_ORIGIN_Z       = 3'd6;

    // wall or face pair picked by the weight compare
    typedef enum logic [1:0] {
        PAIR_Z,
        PAIR_Y,
        PAIR_X
    } pair_t;

    typedef struct packed {
        logic [MODE_BITS-1:0] mode;
        logic [RAND_BITS-1:0] pick_random;
        logic [RAND_BITS-1:0] side_random;
        logic [RAND_BITS-1:0] rand_x;
        logic [RAND_BITS-1:0] rand_y;
        logic [RAND_BITS-1:0] rand_z;
    } item_t;

    typedef struct packed {
        logic signed [POS_BITS-1:0] pos_x;
        logic signed [POS_BITS-1:0] pos_y;
        logic signed [POS_BITS-1:0] pos_z;
        logic                       bad_mode;
    } result_t;

endpackage

// ===== hw/rtl/box_shell_point_sampler.sv =====
`timescale 1ns / 1ps

// channel   handshake               payload
// item      item_valid/item_stall    item (bsps_pkg::item_t)
// result    result_valid/result_stall result (bsps_pkg::result_t)
// cfg       cfg_valid/cfg_ready      cfg_index, cfg_data
//
// one item per cycle while item_stall is low; a taken item passes the input register,
// pair compare with offset products, rounding and saturation, then the result register
// a write to a known register holds item_stall high while the wall and face
// weights and their running sums are rebuilt through the two multiplier steps
// reset loads the register defaults and clears all weights to zero
// result_stall holds a stage only while every stage after it is full; each stage refills as it empties

`include "box_shell_point_sampler_macros.svh"

module box_shell_point_sampler #(
    parameter int LENGTH_BITS = 16
) (
    input  logic                                      clk,
    input  logic                                      rst_n,
    input  logic                                      item_valid,
    output logic                                      item_stall,
    input  bsps_pkg::item_t                           item,
    output logic                                      result_valid,
    input  logic                                      result_stall,
    output bsps_pkg::result_t                         result,
    input  logic                                      cfg_valid,
    output logic                                      cfg_ready,
    input  logic [bsps_pkg::CFG_INDEX_BITS-1:0]       cfg_index,
    input  logic [((LENGTH_BITS > bsps_pkg::ORIGIN_BITS) ?
                   LENGTH_BITS : bsps_pkg::ORIGIN_BITS)-1:0] cfg_data
);

    // widths
    localparam int LB    = LENGTH_BITS;
    localparam int RB    = bsps_pkg::RAND_BITS;
    localparam int GB    = bsps_pkg::ORIGIN_BITS;
    localparam int PB    = bsps_pkg::POS_BITS;
    localparam int OB    = LB + 2;            // outer size
    localparam int OXOYW = 2 * OB;
    localparam int OXTW  = OB + LB;
    localparam int TIYW  = 2 * LB;
    localparam int ZWW   = 2 * OB + LB;       // z wall weight
    localparam int YWW   = OB + 2 * LB;       // y wall weight
    localparam int XWW   = 3 * LB;            // x wall weight
    localparam int FW    = 2 * LB;            // face weights
    localparam int TW    = ZWW + 2;           // running sums, widest set
    localparam int HW    = (TW + 1) / 2;      // split of the pick multiply
    localparam int HIW   = TW - HW;
    localparam int LOPW  = HW + RB;
    localparam int HIPW  = HIW + RB;
    localparam int LW    = TW + RB;           // scaled compare width
    localparam int CB    = LB + 3;            // twice the centre, signed
    localparam int PW    = RB + OB + 1;       // offset product, signed
    localparam int AW    = RB + LB + 5;       // rounding accumulator
    localparam int QW    = AW - RB;
    localparam int SW    = ((QW > GB) ? QW : GB) + 1;

    localparam logic [1:0] RECOMP_STEPS = 2'd3;
    localparam logic signed [AW-1:0] HALF_ACC = {{(AW - RB){1'b0}}, 1'b1, {(RB - 1){1'b0}}};

    // ------------------------------------------------------------------
    // configuration registers
    // ------------------------------------------------------------------
    logic [LB-1:0]        inner_x_reg, inner_y_reg, inner_z_reg, wall_reg;
    logic signed [GB-1:0] origin_x_reg, origin_y_reg, origin_z_reg;
    logic                 cfg_wr;
    logic                 cfg_known;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready;
    assign cfg_known = (cfg_index <= bsps_pkg::CFG_ORIGIN_Z);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            inner_x_reg  <= LB'(bsps_pkg::INNER_RESET);
            inner_y_reg  <= LB'(bsps_pkg::INNER_RESET);
            inner_z_reg  <= LB'(bsps_pkg::INNER_RESET);
            wall_reg     <= LB'(bsps_pkg::WALL_RESET);
            origin_x_reg <= '0;
            origin_y_reg <= '0;
            origin_z_reg <= '0;
        end
        else if (cfg_wr)
        begin
            case (cfg_index)
                bsps_pkg::CFG_INNER_X:        inner_x_reg  <= cfg_data[LB-1:0];
                bsps_pkg::CFG_INNER_Y:        inner_y_reg  <= cfg_data[LB-1:0];
                bsps_pkg::CFG_INNER_Z:        inner_z_reg  <= cfg_data[LB-1:0];
                bsps_pkg::CFG_WALL_THICKNESS: wall_reg     <= cfg_data[LB-1:0];
                bsps_pkg::CFG_ORIGIN_X:       origin_x_reg <= signed'(cfg_data[GB-1:0]);
                bsps_pkg::CFG_ORIGIN_Y:       origin_y_reg <= signed'(cfg_data[GB-1:0]);
                bsps_pkg::CFG_ORIGIN_Z:       origin_z_reg <= signed'(cfg_data[GB-1:0]);
                default:                      ;
            endcase
        end
    end

    // outer sizes, inner + two walls
    logic [OB-1:0] outer_x, outer_y;
    assign outer_x = OB'(inner_x_reg) + (OB'(wall_reg) << 1);
    assign outer_y = OB'(inner_y_reg) + (OB'(wall_reg) << 1);

    // ------------------------------------------------------------------
    // weight rebuild: three steps after every write to a known register
    //   step 3: first products and the face weights
    //   step 2: wall weights, face running sums
    //   step 1: wall running sums
    // weights stay zero from reset until the first such write
    // ------------------------------------------------------------------
    logic [1:0]       busy_reg;
    logic [OXOYW-1:0] oxoy_reg;
    logic [OXTW-1:0]  oxt_reg;
    logic [TIYW-1:0]  tiy_reg;
    logic [ZWW-1:0]   z_wall_weight_reg;
    logic [YWW-1:0]   y_wall_weight_reg;
    logic [XWW-1:0]   x_wall_weight_reg;
    logic [FW-1:0]    z_face_weight_reg, y_face_weight_reg, x_face_weight_reg;
    logic [ZWW:0]     wall_cum_reg;
    logic [TW-1:0]    wall_total_reg;
    logic [FW:0]      face_cum_reg;
    logic [FW+1:0]    face_total_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 2'd0;
        end
        else if (cfg_wr && cfg_known)
        begin
            busy_reg <= RECOMP_STEPS;
        end
        else if (busy_reg != 2'd0)
        begin
            busy_reg <= busy_reg - 2'd1;
        end
    end

    // first products, no reset needed
    always_ff @(posedge clk)
    begin
        if (busy_reg == 2'd3)
        begin
            oxoy_reg <= OXOYW'(outer_x) * OXOYW'(outer_y);
            oxt_reg  <= OXTW'(outer_x) * OXTW'(wall_reg);
            tiy_reg  <= TIYW'(wall_reg) * TIYW'(inner_y_reg);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            z_wall_weight_reg <= '0;
            y_wall_weight_reg <= '0;
            x_wall_weight_reg <= '0;
            z_face_weight_reg <= '0;
            y_face_weight_reg <= '0;
            x_face_weight_reg <= '0;
            wall_cum_reg      <= '0;
            wall_total_reg    <= '0;
            face_cum_reg      <= '0;
            face_total_reg    <= '0;
        end
        else
        begin
            case (busy_reg)
                2'd3:
                begin
                    z_face_weight_reg <= FW'(inner_x_reg) * FW'(inner_y_reg);
                    y_face_weight_reg <= FW'(inner_x_reg) * FW'(inner_z_reg);
                    x_face_weight_reg <= FW'(inner_y_reg) * FW'(inner_z_reg);
                end
                2'd2:
                begin
                    z_wall_weight_reg <= ZWW'(oxoy_reg) * ZWW'(wall_reg);
                    y_wall_weight_reg <= YWW'(oxt_reg) * YWW'(inner_z_reg);
                    x_wall_weight_reg <= XWW'(tiy_reg) * XWW'(inner_z_reg);
                    face_cum_reg      <= (FW + 1)'(z_face_weight_reg)
                                       + (FW + 1)'(y_face_weight_reg);
                    face_total_reg    <= (FW + 2)'(z_face_weight_reg)
                                       + (FW + 2)'(y_face_weight_reg)
                                       + (FW + 2)'(x_face_weight_reg);
                end
                2'd1:
                begin
                    wall_cum_reg   <= (ZWW + 1)'(z_wall_weight_reg)
                                    + (ZWW + 1)'(y_wall_weight_reg);
                    wall_total_reg <= TW'(z_wall_weight_reg)
                                    + TW'(y_wall_weight_reg)
                                    + TW'(x_wall_weight_reg);
                end
                default:
                begin
                end
            endcase
        end
    end

    // ------------------------------------------------------------------
    // stage enables: a stage moves when the one after it is empty or moving
    // ------------------------------------------------------------------
    logic s0_valid_reg, s1_valid_reg, s2_valid_reg, result_valid_reg;
    logic en0, en1, en2, en3;
    logic accept;

    assign en3        = !result_valid_reg || !result_stall;
    assign en2        = !s2_valid_reg || en3;
    assign en1        = !s1_valid_reg || en2;
    assign en0        = !s0_valid_reg || en1;
    assign item_stall = !en0 || (busy_reg != 2'd0);
    assign accept     = item_valid && !item_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s0_valid_reg     <= 1'b0;
            s1_valid_reg     <= 1'b0;
            s2_valid_reg     <= 1'b0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            if (en0)
            begin
                s0_valid_reg <= accept;
            end
            if (en1)
            begin
                s1_valid_reg <= s0_valid_reg;
            end
            if (en2)
            begin
                s2_valid_reg <= s1_valid_reg;
            end
            if (en3)
            begin
                result_valid_reg <= s2_valid_reg;
            end
        end
    end

    // ------------------------------------------------------------------
    // stage 0: input register, pick times total in two halves
    // ------------------------------------------------------------------
    bsps_pkg::item_t s0_item_reg;
    logic [TW-1:0]   cum1_sel, cum2_sel, total_sel;
    logic [LOPW-1:0] pp_lo_next;
    logic [HIPW-1:0] pp_hi_next;

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s0_item_reg <= item;
        end
    end

    // all faces uses the face weights, everything else the wall weights
    always_comb
    begin
        if (s0_item_reg.mode == bsps_pkg::MODE_ALL_FACES)
        begin
            cum1_sel  = TW'(z_face_weight_reg);
            cum2_sel  = TW'(face_cum_reg);
            total_sel = TW'(face_total_reg);
        end
        else
        begin
            cum1_sel  = TW'(z_wall_weight_reg);
            cum2_sel  = TW'(wall_cum_reg);
            total_sel = wall_total_reg;
        end
        pp_lo_next = LOPW'(total_sel[HW-1:0]) * LOPW'(s0_item_reg.pick_random);
        pp_hi_next = HIPW'(total_sel[TW-1:HW]) * HIPW'(s0_item_reg.pick_random);
    end

    // ------------------------------------------------------------------
    // stage 1: pair compare, geometry select, offset products
    // ------------------------------------------------------------------
    bsps_pkg::item_t s1_item_reg;
    logic [LOPW-1:0] pp_lo_reg;
    logic [HIPW-1:0] pp_hi_reg;
    logic [TW-1:0]   cum1_reg, cum2_reg;

    always_ff @(posedge clk)
    begin
        if (en1 && s0_valid_reg)
        begin
            s1_item_reg <= s0_item_reg;
            pp_lo_reg   <= pp_lo_next;
            pp_hi_reg   <= pp_hi_next;
            cum1_reg    <= cum1_sel;
            cum2_reg    <= cum2_sel;
        end
    end

    logic [LW-1:0]        lhs, thr1, thr2;
    bsps_pkg::pair_t      pair;
    logic                 first;
    logic signed [CB-1:0] ix_c, iy_c, iz_c, ixt_c, iyt_c, izt_c;
    logic signed [CB-1:0] cx, cy, cz;
    logic [OB-1:0]        lx, ly, lz;
    logic [OB-1:0]        ix_l, iy_l, iz_l, t_l;
    logic signed [RB-1:0] rs_x, rs_y, rs_z;
    logic signed [PW-1:0] prod_x_next, prod_y_next, prod_z_next;
    logic                 zero_next, bad_next;

    assign lhs  = LW'(pp_lo_reg) + (LW'(pp_hi_reg) << HW);
    assign thr1 = {cum1_reg, {RB{1'b0}}};
    assign thr2 = {cum2_reg, {RB{1'b0}}};

    // equality falls through to the next pair; all-zero weights land on x
    always_comb
    begin
        if (lhs < thr1)
        begin
            pair = bsps_pkg::PAIR_Z;
        end
        else if (lhs < thr2)
        begin
            pair = bsps_pkg::PAIR_Y;
        end
        else
        begin
            pair = bsps_pkg::PAIR_X;
        end
    end

    assign first = !s1_item_reg.side_random[RB-1];

    assign ix_c  = signed'(CB'(inner_x_reg));
    assign iy_c  = signed'(CB'(inner_y_reg));
    assign iz_c  = signed'(CB'(inner_z_reg));
    assign ixt_c = signed'(CB'(inner_x_reg) + CB'(wall_reg));
    assign iyt_c = signed'(CB'(inner_y_reg) + CB'(wall_reg));
    assign izt_c = signed'(CB'(inner_z_reg) + CB'(wall_reg));
    assign ix_l  = OB'(inner_x_reg);
    assign iy_l  = OB'(inner_y_reg);
    assign iz_l  = OB'(inner_z_reg);
    assign t_l   = OB'(wall_reg);

    // twice the centre and the span on each axis
    always_comb
    begin
        cx        = '0;
        cy        = '0;
        cz        = '0;
        lx        = '0;
        ly        = '0;
        lz        = '0;
        zero_next = 1'b0;
        bad_next  = 1'b0;
        case (s1_item_reg.mode)
            bsps_pkg::MODE_CENTRE:
            begin
                zero_next = 1'b1;
            end
            bsps_pkg::MODE_Z_ENDCAP:
            begin
                lx = outer_x;
                ly = outer_y;
                cz = -izt_c;
                lz = t_l;
            end
            bsps_pkg::MODE_SHELL:
            begin
                case (pair)
                    bsps_pkg::PAIR_Z:
                    begin
                        lx = outer_x;
                        ly = outer_y;
                        cz = first ? -izt_c : izt_c;
                        lz = t_l;
                    end
                    bsps_pkg::PAIR_Y:
                    begin
                        lx = outer_x;
                        cy = first ? -iyt_c : iyt_c;
                        ly = t_l;
                        lz = iz_l;
                    end
                    default:
                    begin
                        cx = first ? -ixt_c : ixt_c;
                        lx = t_l;
                        ly = iy_l;
                        lz = iz_l;
                    end
                endcase
            end
            bsps_pkg::MODE_INSIDE:
            begin
                lx = ix_l;
                ly = iy_l;
                lz = iz_l;
            end
            bsps_pkg::MODE_Z_FACE:
            begin
                lx = ix_l;
                ly = iy_l;
                cz = -iz_c;
            end
            bsps_pkg::MODE_ALL_FACES:
            begin
                // plus side first on the faces
                case (pair)
                    bsps_pkg::PAIR_Z:
                    begin
                        lx = ix_l;
                        ly = iy_l;
                        cz = first ? iz_c : -iz_c;
                    end
                    bsps_pkg::PAIR_Y:
                    begin
                        lx = ix_l;
                        cy = first ? iy_c : -iy_c;
                        lz = iz_l;
                    end
                    default:
                    begin
                        cx = first ? ix_c : -ix_c;
                        ly = iy_l;
                        lz = iz_l;
                    end
                endcase
            end
            default:
            begin
                zero_next = 1'b1;
                bad_next  = 1'b1;
            end
        endcase
    end

    // r - 1/2 is the fraction with its top bit flipped, read as signed
    assign rs_x = signed'({~s1_item_reg.rand_x[RB-1], s1_item_reg.rand_x[RB-2:0]});
    assign rs_y = signed'({~s1_item_reg.rand_y[RB-1], s1_item_reg.rand_y[RB-2:0]});
    assign rs_z = signed'({~s1_item_reg.rand_z[RB-1], s1_item_reg.rand_z[RB-2:0]});

    assign prod_x_next = PW'(rs_x) * PW'(signed'({1'b0, lx}));
    assign prod_y_next = PW'(rs_y) * PW'(signed'({1'b0, ly}));
    assign prod_z_next = PW'(rs_z) * PW'(signed'({1'b0, lz}));

    // ------------------------------------------------------------------
    // stage 2: centre plus offset, round half up, translate, saturate
    // ------------------------------------------------------------------
    logic signed [PW-1:0] prod_x_reg, prod_y_reg, prod_z_reg;
    logic signed [CB-1:0] cx_reg, cy_reg, cz_reg;
    logic                 zero_reg, bad_reg;

    always_ff @(posedge clk)
    begin
        if (en2 && s1_valid_reg)
        begin
            prod_x_reg <= prod_x_next;
            prod_y_reg <= prod_y_next;
            prod_z_reg <= prod_z_next;
            cx_reg     <= cx;
            cy_reg     <= cy;
            cz_reg     <= cz;
            zero_reg   <= zero_next;
            bad_reg    <= bad_next;
        end
    end

    function automatic logic signed [PB-1:0] place(
        input logic signed [CB-1:0] centre2,
        input logic signed [PW-1:0] prod,
        input logic signed [GB-1:0] shift
    );
        logic signed [AW-1:0] acc;
        logic signed [QW-1:0] whole;
        logic signed [SW-1:0] sum;
        acc   = (AW'(centre2) <<< (RB - 1)) + AW'(prod) + HALF_ACC;
        whole = signed'(acc[AW-1:RB]);
        sum   = SW'(whole) + SW'(shift);
        if (sum > SW'(bsps_pkg::POS_MAX))
        begin
            return bsps_pkg::POS_MAX;
        end
        else if (sum < SW'(bsps_pkg::POS_MIN))
        begin
            return bsps_pkg::POS_MIN;
        end
        return PB'(sum);
    endfunction

    bsps_pkg::result_t result_next;
    bsps_pkg::result_t result_reg;

    always_comb
    begin
        result_next.bad_mode = bad_reg;
        if (zero_reg)
        begin
            result_next.pos_x = '0;
            result_next.pos_y = '0;
            result_next.pos_z = '0;
        end
        else
        begin
            result_next.pos_x = place(cx_reg, prod_x_reg, origin_x_reg);
            result_next.pos_y = place(cy_reg, prod_y_reg, origin_y_reg);
            result_next.pos_z = place(cz_reg, prod_z_reg, origin_z_reg);
        end
    end

    // result register parts the result side from the pipeline
    always_ff @(posedge clk)
    begin
        if (en3 && s2_valid_reg)
        begin
            result_reg <= result_next;
        end
    end

    assign result_valid = result_valid_reg;
    assign result       = result_reg;

    // ------------------------------------------------------------------
    // checks
    // ------------------------------------------------------------------
    `BSPS_ASSERT_NOW(a_no_take_in_update, clk, rst_n, item_valid && !item_stall, busy_reg == 2'd0, "item taken while weights rebuild")
    `BSPS_ASSERT_NEXT(a_write_starts_update, clk, rst_n, cfg_valid && cfg_ready && cfg_known, busy_reg == RECOMP_STEPS, "register write did not start weight rebuild")
    `BSPS_ASSERT_NEXT(a_stage_to_result, clk, rst_n, s2_valid_reg && en3, result_valid, "finished item did not reach result")
    `BSPS_ASSERT_NOW(a_bad_is_zero, clk, rst_n, result_valid && result.bad_mode, result.pos_x == '0 && result.pos_y == '0 && result.pos_z == '0, "unknown mode with nonzero position")

endmodule
